/* rtl/lhm_pkg.sv */
// ----------------------------------------------------------------------------
// lhm_pkg: shared types, tables and helpers of the luma heightmap pipeline
// Stage numbering, configuration record, permutation and transition tables,
// reciprocal constants and the 2D gradient function.
// ----------------------------------------------------------------------------
package lhm_pkg;

  // pipeline stages, one register each
  localparam int NSTG = 11;
  localparam int ST_A = 0;
  localparam int ST_B = 1;
  localparam int ST_C = 2;
  localparam int ST_D = 3;
  localparam int ST_E = 4;
  localparam int ST_F = 5;
  localparam int ST_G = 6;
  localparam int ST_H = 7;
  localparam int ST_I = 8;
  localparam int ST_J = 9;
  localparam int ST_K = 10;

  localparam int PIX_COORD_W = 12;

  typedef logic [NSTG-1:0] stage_en_t;

  typedef struct packed {
    logic [15:0]        min_base_height;
    logic [15:0]        max_base_height;
    logic [23:0]        mountain_scale;
    logic [23:0]        valley_scale;
    logic signed [15:0] mountain_gain;
    logic signed [15:0] valley_gain;
    logic [7:0]         height_limit;
  } lhm_cfg_t;

  // luma sum thresholds (sum = 299 r + 587 g + 114 b)
  localparam logic [17:0] S_HALF = 18'd127500;
  localparam logic [17:0] S_LOW  = 18'd51000;
  localparam logic [17:0] S_HIGH = 18'd204000;
  localparam logic [18:0] S_FULL = 19'd255000;

  // x*2^13/31875 and x*2^13/19125 by reciprocal multiplication
  localparam logic [31:0] RCP_BASE   = 32'd2207646876; // floor(2^46/31875)
  localparam logic [30:0] RCP_ADJ    = 31'd1839705730; // floor(2^45/19125)
  localparam logic [30:0] RCP_FACTOR = 31'd1103823438; // floor(2^45/31875)
  localparam logic [14:0] DIV_BASE   = 15'd31875;
  localparam logic [14:0] DIV_ADJ    = 15'd19125;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,
    8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,
    8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190,
    8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177,
    8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136,
    8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,
    8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,
    8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161,
    8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
    8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126,
    8'd255, 8'd82,  8'd85,  8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,
    8'd58,  8'd17,  8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,  8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,   8'd129, 8'd22,  8'd39,  8'd253,
    8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241, 8'd81,  8'd51,
    8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107, 8'd49,  8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121,
    8'd50,  8'd45,  8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141, 8'd128, 8'd195,
    8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // raised cosine, 65536*(1-cos(pi*k/16))/2
  localparam logic [16:0] TRANS [17] = '{
    17'd0,     17'd630,   17'd2494,  17'd5522,  17'd9598,  17'd14563,
    17'd20228, 17'd26375, 17'd32768, 17'd39161, 17'd45308, 17'd50973,
    17'd55938, 17'd60014, 17'd63042, 17'd64906, 17'd65536
  };

  function automatic logic [7:0] perm(logic [7:0] idx);
    return PERM[idx];
  endfunction

  function automatic logic [16:0] trans_lo(logic [4:0] idx);
    logic [16:0] r;
    if (idx > 5'd16) r = TRANS[16];
    else             r = TRANS[idx];
    return r;
  endfunction

  function automatic logic [12:0] trans_diff(logic [4:0] idx);
    logic [16:0] r;
    if (idx < 5'd16) r = TRANS[idx + 5'd1] - TRANS[idx];
    else             r = '0;
    return r[12:0];
  endfunction

  // improved-noise gradient, z = 0
  function automatic logic signed [18:0] grad2(logic [7:0] hash,
                                               logic signed [16:0] x,
                                               logic signed [16:0] y);
    logic [3:0]         h;
    logic signed [18:0] u;
    logic signed [18:0] v;
    h = hash[3:0];
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    if (h < 4'd4)                    v = 19'(y);
    else if (h == 4'd12 || h == 4'd14) v = 19'(x);
    else                             v = '0;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

/* rtl/lhm_if.sv */
// ----------------------------------------------------------------------------
// lhm_if: pixel and height stream channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lhm_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] col;
  logic [11:0] row;
  logic [31:0] time_offset;

  modport source (output valid, red, green, blue, col, row, time_offset, input ready);
  modport sink   (input valid, red, green, blue, col, row, time_offset, output ready);
endinterface

interface lhm_hgt_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;

  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

/* rtl/luma_to_perlin_heightmap_top.sv */
// ----------------------------------------------------------------------------
// luma_to_perlin_heightmap_top: pixel to terrain height
// Each pixel transfer yields one clamped height byte.
// ----------------------------------------------------------------------------
// Channels: pix_i takes RGB, grid column and row and a Q16.16 time offset;
// hgt_o gives one height byte per pixel, in order. Both are valid/ready.
// Stages: eleven register stages (luma and coordinate scaling, hashing and
// fade curves, reciprocal divides, blend, three weighting multiplies, clamp);
// the height byte is registered in the last stage.
// Throughput: one pixel per cycle while hgt_o is ready or a stage is empty;
// the rate is set by the single-issue stages, each holding one pixel.
// Stall: when hgt_o is not ready, a stage only holds if every stage after it
// is full, so bubbles are squeezed out and pix_i stays ready until the whole
// pipeline is full.
// Reset: clears all stage valid bits and loads the register defaults.
// Configuration: APB, register i at byte address 4*i, written in the access
// phase; pready is always high. Write only while the pipeline is empty.
// ----------------------------------------------------------------------------
module luma_to_perlin_heightmap_top #(
  parameter int COORD_WIDTH = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lhm_pix_if.sink       pix_i,
  lhm_hgt_if.source     hgt_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import lhm_pkg::*;

  localparam logic [2:0] REG_MIN_BASE   = 3'd0;
  localparam logic [2:0] REG_MAX_BASE   = 3'd1;
  localparam logic [2:0] REG_MTN_SCALE  = 3'd2;
  localparam logic [2:0] REG_VAL_SCALE  = 3'd3;
  localparam logic [2:0] REG_MTN_GAIN   = 3'd4;
  localparam logic [2:0] REG_VAL_GAIN   = 3'd5;
  localparam logic [2:0] REG_HGT_LIMIT  = 3'd6;

  lhm_cfg_t           cfg_q;
  logic [2:0]         reg_idx;
  logic               wr_en;
  stage_en_t          en;
  logic               bright_a, bright_g;
  logic [31:0]        base_g;
  logic [16:0]        w_g, factor_g;
  logic signed [20:0] n_g;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_base_height <= 16'd0;
      cfg_q.max_base_height <= 16'd65280;
      cfg_q.mountain_scale  <= 24'd6554;
      cfg_q.valley_scale    <= 24'd3277;
      cfg_q.mountain_gain   <= 16'sd7680;
      cfg_q.valley_gain     <= -16'sd2560;
      cfg_q.height_limit    <= 8'd255;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_BASE:  cfg_q.min_base_height <= pwdata[15:0];
        REG_MAX_BASE:  cfg_q.max_base_height <= pwdata[15:0];
        REG_MTN_SCALE: cfg_q.mountain_scale  <= pwdata[23:0];
        REG_VAL_SCALE: cfg_q.valley_scale    <= pwdata[23:0];
        REG_MTN_GAIN:  cfg_q.mountain_gain   <= pwdata[15:0];
        REG_VAL_GAIN:  cfg_q.valley_gain     <= pwdata[15:0];
        REG_HGT_LIMIT: cfg_q.height_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_BASE:  prdata = {16'b0, cfg_q.min_base_height};
      REG_MAX_BASE:  prdata = {16'b0, cfg_q.max_base_height};
      REG_MTN_SCALE: prdata = {8'b0, cfg_q.mountain_scale};
      REG_VAL_SCALE: prdata = {8'b0, cfg_q.valley_scale};
      REG_MTN_GAIN:  prdata = {16'b0, cfg_q.mountain_gain};
      REG_VAL_GAIN:  prdata = {16'b0, cfg_q.valley_gain};
      REG_HGT_LIMIT: prdata = {24'b0, cfg_q.height_limit};
      default:       prdata = '0;
    endcase
  end

  lhm_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .out_ready_i (hgt_o.ready),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (hgt_o.valid),
    .en_o        (en)
  );

  lhm_luma u_luma (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .red_i      (pix_i.red),
    .green_i    (pix_i.green),
    .blue_i     (pix_i.blue),
    .bright_a_o (bright_a),
    .bright_g_o (bright_g),
    .base_g_o   (base_g),
    .w_g_o      (w_g),
    .factor_g_o (factor_g)
  );

  lhm_noise #(.COORD_WIDTH(COORD_WIDTH)) u_noise (
    .clk_i         (clk_i),
    .en_i          (en),
    .cfg_i         (cfg_q),
    .col_i         (pix_i.col),
    .row_i         (pix_i.row),
    .time_offset_i (pix_i.time_offset),
    .bright_a_i    (bright_a),
    .n_g_o         (n_g)
  );

  lhm_mix u_mix (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .n_g_i      (n_g),
    .factor_g_i (factor_g),
    .w_g_i      (w_g),
    .base_g_i   (base_g),
    .bright_g_i (bright_g),
    .height_o   (hgt_o.height)
  );
endmodule

/* rtl/lhm_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// lhm_pipe_ctrl: stage valid bits and per-stage load enables
// A stage loads when it is empty or everything downstream can move.
// ----------------------------------------------------------------------------
module lhm_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output lhm_pkg::stage_en_t en_o
);
  import lhm_pkg::*;

  stage_en_t vld_q, vld_d;
  stage_en_t en;

  // a bubble anywhere from stage k onwards lets stage k advance
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_ready_i || !(&(vld_q | stage_en_t'((1 << k) - 1)));
    end
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (k == 0) vld_d[k] = en[k] ? in_valid_i : vld_q[k];
      else        vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[ST_A];
  assign out_valid_o = vld_q[ST_K];
endmodule

/* rtl/lhm_luma.sv */
// ----------------------------------------------------------------------------
// lhm_luma: luma, base height, transition weight and noise factor
// Stages A..G; divisions by constants by reciprocal and remainder fix-up.
// ----------------------------------------------------------------------------
module lhm_luma (
  input  logic               clk_i,
  input  lhm_pkg::stage_en_t en_i,
  input  lhm_pkg::lhm_cfg_t  cfg_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               bright_a_o,
  output logic               bright_g_o,
  output logic [31:0]        base_g_o,
  output logic [16:0]        w_g_o,
  output logic [16:0]        factor_g_o
);
  import lhm_pkg::*;

  // stage A
  logic [17:0] s_a_q, s_d;
  logic        bright_a_q;
  // stage B
  logic [33:0] x_b_q, x_d;
  logic [17:0] v_b_q, a_b_q, a_d;
  logic        dneg_b_q, lo_b_q, hi_b_q, bright_b_q;
  logic [15:0] dabs;
  logic [18:0] s2;
  // stage C
  logic [63:0] pb;
  logic [48:0] pa, pf;
  logic [31:0] qb_c_q;
  logic [16:0] qa_c_q, qf_c_q;
  logic [33:0] x_c_q;
  logic [17:0] v_c_q, a_c_q;
  logic        dneg_c_q, lo_c_q, hi_c_q, bright_c_q;
  // stage D
  logic [46:0] rb;
  logic [31:0] ra, rf;
  logic [1:0]  kb;
  logic [31:0] mag_d_q;
  logic [16:0] adj_d_q, adj_d, factor_d_q;
  logic        dneg_d_q, bright_d_q;
  // stage E
  logic [33:0] base_sum;
  logic [31:0] base_e_q;
  logic [16:0] tl_e_q, factor_e_q;
  logic [24:0] tm_e_q;
  logic        bright_e_q;
  // stage F
  logic [16:0] tr;
  logic [31:0] base_f_q;
  logic [16:0] w_f_q, factor_f_q;
  logic        bright_f_q;
  // stage G
  logic [31:0] base_g_q;
  logic [16:0] w_g_q, factor_g_q;
  logic        bright_g_q;

  assign s_d = 18'd299 * red_i + 18'd587 * green_i + 18'd114 * blue_i;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_A]) begin
      s_a_q      <= s_d;
      bright_a_q <= (s_d >= S_HALF);
    end
  end

  assign dabs = (cfg_i.max_base_height >= cfg_i.min_base_height) ?
                cfg_i.max_base_height - cfg_i.min_base_height :
                cfg_i.min_base_height - cfg_i.max_base_height;
  assign x_d  = s_a_q * dabs;
  assign s2   = {s_a_q, 1'b0};
  assign a_d  = 18'(bright_a_q ? s2 - S_FULL : S_FULL - s2);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_B]) begin
      x_b_q      <= x_d;
      v_b_q      <= s_a_q - S_LOW;
      a_b_q      <= a_d;
      dneg_b_q   <= (cfg_i.max_base_height < cfg_i.min_base_height);
      lo_b_q     <= (s_a_q <= S_LOW);
      hi_b_q     <= (s_a_q >= S_HIGH);
      bright_b_q <= bright_a_q;
    end
  end

  // quotient estimates, at most a few below the exact value
  assign pb = x_b_q[33:2] * RCP_BASE;
  assign pa = v_b_q * RCP_ADJ;
  assign pf = a_b_q * RCP_FACTOR;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_C]) begin
      qb_c_q     <= pb[62:31];
      qa_c_q     <= pa[48:32];
      qf_c_q     <= pf[48:32];
      x_c_q      <= x_b_q;
      v_c_q      <= v_b_q;
      a_c_q      <= a_b_q;
      dneg_c_q   <= dneg_b_q;
      lo_c_q     <= lo_b_q;
      hi_c_q     <= hi_b_q;
      bright_c_q <= bright_b_q;
    end
  end

  // remainder fix-up
  assign rb = {x_c_q, 13'b0} - qb_c_q * DIV_BASE;
  assign ra = {1'b0, v_c_q, 13'b0} - qa_c_q * DIV_ADJ;
  assign rf = {1'b0, a_c_q, 13'b0} - qf_c_q * DIV_BASE;
  assign kb = 2'(rb >= 47'(DIV_BASE)) + 2'(rb >= 47'(2 * DIV_BASE))
            + 2'(rb >= 47'(3 * DIV_BASE));

  always_comb begin
    if (lo_c_q)      adj_d = '0;
    else if (hi_c_q) adj_d = 17'd65536;
    else             adj_d = qa_c_q + 17'(ra >= 32'(DIV_ADJ));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_D]) begin
      mag_d_q    <= qb_c_q + 32'(kb);
      adj_d_q    <= adj_d;
      factor_d_q <= qf_c_q + 17'(rf >= 32'(DIV_BASE));
      dneg_d_q   <= dneg_c_q;
      bright_d_q <= bright_c_q;
    end
  end

  assign base_sum = {2'b0, cfg_i.min_base_height, 16'b0}
                  + (dneg_d_q ? -{2'b0, mag_d_q} : {2'b0, mag_d_q});

  always_ff @(posedge clk_i) begin
    if (en_i[ST_E]) begin
      base_e_q   <= base_sum[31:0];
      tl_e_q     <= trans_lo(adj_d_q[16:12]);
      tm_e_q     <= trans_diff(adj_d_q[16:12]) * adj_d_q[11:0];
      factor_e_q <= factor_d_q;
      bright_e_q <= bright_d_q;
    end
  end

  assign tr = tl_e_q + 17'(tm_e_q[24:12]);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_F]) begin
      base_f_q   <= base_e_q;
      w_f_q      <= bright_e_q ? tr : 17'd65536 - tr;
      factor_f_q <= factor_e_q;
      bright_f_q <= bright_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_G]) begin
      base_g_q   <= base_f_q;
      w_g_q      <= w_f_q;
      factor_g_q <= factor_f_q;
      bright_g_q <= bright_f_q;
    end
  end

  assign bright_a_o = bright_a_q;
  assign bright_g_o = bright_g_q;
  assign base_g_o   = base_g_q;
  assign w_g_o      = w_g_q;
  assign factor_g_o = factor_g_q;
endmodule

/* rtl/lhm_noise.sv */
// ----------------------------------------------------------------------------
// lhm_noise: 2D improved gradient noise
// Stages A..G: coordinates, scaling, hashing, fade curves and bilinear blend.
// ----------------------------------------------------------------------------
module lhm_noise #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                clk_i,
  input  lhm_pkg::stage_en_t  en_i,
  input  lhm_pkg::lhm_cfg_t   cfg_i,
  input  logic [11:0]         col_i,
  input  logic [11:0]         row_i,
  input  logic [31:0]         time_offset_i,
  input  logic                bright_a_i,
  output logic signed [20:0]  n_g_o
);
  import lhm_pkg::*;

  localparam int CU = (COORD_WIDTH < PIX_COORD_W) ? COORD_WIDTH : PIX_COORD_W;
  localparam logic [PIX_COORD_W-1:0] CMASK = PIX_COORD_W'((1 << CU) - 1);

  // stage A
  logic [31:0] cx_a_q, cy_a_q;
  // stage B
  logic [23:0] scl;
  logic [55:0] px, py;
  logic [7:0]  xi_b_q, yi_b_q;
  logic [15:0] xf_b_q, yf_b_q;
  // stage C
  logic [31:0] sqx, sqy;
  logic [7:0]  ha_c_q, hb_c_q;
  logic [15:0] t2x_c_q, t2y_c_q, xf_c_q, yf_c_q;
  // stage D
  logic [31:0] cbx, cby;
  logic [21:0] qx, qy;
  logic [7:0]  aa_d_q, ab_d_q, ba_d_q, bb_d_q;
  logic [15:0] t3x_d_q, t3y_d_q, xf_d_q, yf_d_q;
  logic [19:0] qx_d_q, qy_d_q;
  // stage E
  logic [35:0]        fx, fy;
  logic signed [16:0] x0, x1, y0, y1;
  logic signed [18:0] g1_e_q, g2_e_q, g3_e_q, g4_e_q;
  logic [16:0]        ux_e_q, uy_e_q;
  // stage F
  logic signed [17:0] uxs, uys;
  logic signed [19:0] dxa, dxb;
  logic signed [37:0] pxa, pxb;
  logic signed [19:0] l1_f_q, l2_f_q, l1_d, l2_d;
  logic [16:0]        uy_f_q;
  // stage G
  logic signed [20:0] dl;
  logic signed [37:0] pl;
  logic signed [20:0] lsum;
  logic signed [21:0] nsum;
  logic signed [20:0] n_g_q;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_A]) begin
      cx_a_q <= {4'b0, col_i & CMASK, 16'b0} + time_offset_i;
      cy_a_q <= {4'b0, row_i & CMASK, 16'b0} + time_offset_i;
    end
  end

  assign scl = bright_a_i ? cfg_i.mountain_scale : cfg_i.valley_scale;
  assign px  = cx_a_q * scl;
  assign py  = cy_a_q * scl;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_B]) begin
      xi_b_q <= px[39:32];
      xf_b_q <= px[31:16];
      yi_b_q <= py[39:32];
      yf_b_q <= py[31:16];
    end
  end

  assign sqx = xf_b_q * xf_b_q;
  assign sqy = yf_b_q * yf_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_C]) begin
      ha_c_q  <= perm(xi_b_q) + yi_b_q;
      hb_c_q  <= perm(xi_b_q + 8'd1) + yi_b_q;
      t2x_c_q <= sqx[31:16];
      t2y_c_q <= sqy[31:16];
      xf_c_q  <= xf_b_q;
      yf_c_q  <= yf_b_q;
    end
  end

  assign cbx = t2x_c_q * xf_c_q;
  assign cby = t2y_c_q * yf_c_q;
  assign qx  = 22'd655360 + 22'd6 * t2x_c_q - 22'd15 * xf_c_q;
  assign qy  = 22'd655360 + 22'd6 * t2y_c_q - 22'd15 * yf_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_D]) begin
      aa_d_q  <= perm(ha_c_q);
      ab_d_q  <= perm(ha_c_q + 8'd1);
      ba_d_q  <= perm(hb_c_q);
      bb_d_q  <= perm(hb_c_q + 8'd1);
      t3x_d_q <= cbx[31:16];
      t3y_d_q <= cby[31:16];
      qx_d_q  <= qx[19:0];
      qy_d_q  <= qy[19:0];
      xf_d_q  <= xf_c_q;
      yf_d_q  <= yf_c_q;
    end
  end

  assign fx = t3x_d_q * qx_d_q;
  assign fy = t3y_d_q * qy_d_q;
  // offset minus one is the fraction with the sign bit set
  assign x0 = {1'b0, xf_d_q};
  assign x1 = {1'b1, xf_d_q};
  assign y0 = {1'b0, yf_d_q};
  assign y1 = {1'b1, yf_d_q};

  always_ff @(posedge clk_i) begin
    if (en_i[ST_E]) begin
      g1_e_q <= grad2(perm(aa_d_q), x0, y0);
      g2_e_q <= grad2(perm(ba_d_q), x1, y0);
      g3_e_q <= grad2(perm(ab_d_q), x0, y1);
      g4_e_q <= grad2(perm(bb_d_q), x1, y1);
      ux_e_q <= fx[32:16];
      uy_e_q <= fy[32:16];
    end
  end

  assign uxs  = {1'b0, ux_e_q};
  assign dxa  = g2_e_q - g1_e_q;
  assign dxb  = g4_e_q - g3_e_q;
  assign pxa  = uxs * dxa;
  assign pxb  = uxs * dxb;
  assign l1_d = g1_e_q + $signed(pxa[35:16]);
  assign l2_d = g3_e_q + $signed(pxb[35:16]);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_F]) begin
      l1_f_q <= l1_d;
      l2_f_q <= l2_d;
      uy_f_q <= uy_e_q;
    end
  end

  assign uys  = {1'b0, uy_f_q};
  assign dl   = l2_f_q - l1_f_q;
  assign pl   = uys * dl;
  assign lsum = l1_f_q + $signed(pl[36:16]);
  assign nsum = lsum + 22'sd65536;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_G]) begin
      n_g_q <= nsum[21:1];
    end
  end

  assign n_g_o = n_g_q;
endmodule

/* rtl/lhm_mix.sv */
// ----------------------------------------------------------------------------
// lhm_mix: noise weighting, gain and output clamp
// Stages H..K: noise times factor, times weight, times gain, add and clamp.
// ----------------------------------------------------------------------------
module lhm_mix (
  input  logic               clk_i,
  input  lhm_pkg::stage_en_t en_i,
  input  lhm_pkg::lhm_cfg_t  cfg_i,
  input  logic signed [20:0] n_g_i,
  input  logic [16:0]        factor_g_i,
  input  logic [16:0]        w_g_i,
  input  logic [31:0]        base_g_i,
  input  logic               bright_g_i,
  output logic [7:0]         height_o
);
  import lhm_pkg::*;

  logic signed [17:0] fs, ws;
  logic signed [38:0] p1;
  logic signed [22:0] p1_h_q;
  logic [16:0]        w_h_q;
  logic [31:0]        base_h_q, base_i_q, base_j_q;
  logic               bright_h_q, bright_i_q;
  logic signed [40:0] p2;
  logic signed [24:0] p2_i_q;
  logic signed [15:0] gain;
  logic signed [40:0] e_j_q;
  logic signed [41:0] total;
  logic [7:0]         height_q, height_d;

  assign fs = {1'b0, factor_g_i};
  assign p1 = n_g_i * fs;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_H]) begin
      p1_h_q     <= $signed(p1[38:16]);
      w_h_q      <= w_g_i;
      base_h_q   <= base_g_i;
      bright_h_q <= bright_g_i;
    end
  end

  assign ws = {1'b0, w_h_q};
  assign p2 = p1_h_q * ws;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_I]) begin
      p2_i_q     <= $signed(p2[40:16]);
      base_i_q   <= base_h_q;
      bright_i_q <= bright_h_q;
    end
  end

  assign gain = bright_i_q ? cfg_i.mountain_gain : cfg_i.valley_gain;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_J]) begin
      e_j_q    <= p2_i_q * gain;
      base_j_q <= base_i_q;
    end
  end

  assign total = $signed({10'b0, base_j_q}) + e_j_q;

  always_comb begin
    if (total < 0) begin
      height_d = '0;
    end else if (total[41:24] > 18'(cfg_i.height_limit)) begin
      height_d = cfg_i.height_limit;
    end else begin
      height_d = total[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_K]) begin
      height_q <= height_d;
    end
  end

  assign height_o = height_q;
endmodule

/* rtl/lhm_chk.sv */
// ----------------------------------------------------------------------------
// lhm_chk: port-level checks of the heightmap block
// Output hold under stall and input readiness against output state.
// ----------------------------------------------------------------------------
module lhm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] height_i
);

  // a waiting height stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("height dropped while stalled");

  // and unchanged
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(height_i))
    else $error("height changed while stalled");

  // with nothing waiting at the output the pipeline can always move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with no result pending");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input blocked while output drains");

endmodule

bind luma_to_perlin_heightmap_top lhm_chk u_lhm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hgt_o.valid),
  .out_ready_i (hgt_o.ready),
  .height_i    (hgt_o.height)
);
